FILE: src/xyzr_pkg.sv
// Shared constants and the quarter-wave sine generator for the XYZ rotation matrix core.
package xyzr_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 13;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned Q15_W = 16;
  localparam int unsigned TBL_W = 15;
  localparam logic [63:0] PI_Q45 = 64'h3243F6A8885A308D >> 15;
  localparam logic signed [15:0] Q15_MAX = 16'sd32767;

  // sin(pi/2 * r / 16384) rounded to Q15 and clamped; r runs over 0..16384
  function automatic logic [TBL_W-1:0] quarter_sine_q15(input logic [14:0] r);
    logic [63:0] theta;
    logic [63:0] theta2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    theta  = ({49'd0, r} * PI_Q45) >> 30;
    theta2 = (theta * theta) >> 30;
    term   = theta;
    sum    = $signed(theta);
    for (int k = 1; k <= 10; k++) begin
      term = (term * theta2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[TBL_W-1:0];
  endfunction

endpackage

FILE: src/xyz_euler_rotation_matrix_core.sv
// Top level: pipelined XYZ Euler angle to 3x3 rotation matrix converter, Q1.15.
//
// One input word carries three signed 16-bit angles (65536 units per turn) for
// x, y and z; one output word carries the nine matrix entries m00..m22 in
// Q1.15, rounded half up and saturated to +-32767. Both channels use
// valid/stall: a word moves on a rising edge with valid high and stall low.
//
// Six register stages: quarter-wave sine ROM read, sine/cosine select, pair
// products, triple products, sums with rounding offset, clamp to the output
// register. One word is accepted per cycle while the receiver does not stall;
// each axis has its own ROM with two read ports (sine and cosine addresses).
//
// Reset clears all stage valid bits; no ROM clearing is needed. When the
// receiver stalls, the output word holds and stages fill bubble by bubble;
// in_stall_o rises only once every stage holds a word.
module xyz_euler_rotation_matrix_core
  import xyzr_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [ANGLE_W-1:0] angle_x_i,
  input  logic signed [ANGLE_W-1:0] angle_y_i,
  input  logic signed [ANGLE_W-1:0] angle_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [Q15_W-1:0] m00_o,
  output logic signed [Q15_W-1:0] m01_o,
  output logic signed [Q15_W-1:0] m02_o,
  output logic signed [Q15_W-1:0] m10_o,
  output logic signed [Q15_W-1:0] m11_o,
  output logic signed [Q15_W-1:0] m12_o,
  output logic signed [Q15_W-1:0] m20_o,
  output logic signed [Q15_W-1:0] m21_o,
  output logic signed [Q15_W-1:0] m22_o
);

  localparam int unsigned SHIFT     = ANGLE_W - SINE_TABLE_BITS;
  localparam int unsigned RIDX_W    = SINE_TABLE_BITS - 2;
  localparam int unsigned ADDR_W    = SINE_TABLE_BITS - 1;
  localparam int unsigned QTR       = 1 << RIDX_W;
  localparam int unsigned TBL_DEPTH = QTR + 1;
  localparam int unsigned NSTAGE    = 6;
  localparam int unsigned P2_W      = 2 * Q15_W;
  localparam int unsigned P3_W      = 3 * Q15_W;
  localparam int unsigned SUM_W     = P3_W + 1;
  localparam int unsigned RND_W     = SUM_W - 30;

  // ---------------------------------------------------------------------------
  // Stage control: a stage takes a new word when empty or when the next moves
  // ---------------------------------------------------------------------------
  logic [NSTAGE:1] vld_q;
  logic [NSTAGE:1] rdy;

  always_comb begin
    rdy[NSTAGE] = !vld_q[NSTAGE] || !out_stall_i;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= in_valid_i;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = vld_q[NSTAGE];

  // ---------------------------------------------------------------------------
  // Stages 1 and 2: ROM read and sine/cosine select, one lane per axis
  // ---------------------------------------------------------------------------
  logic [2:0][ANGLE_W-1:0]         angle;
  logic signed [Q15_W-1:0]         sin_q [3];
  logic signed [Q15_W-1:0]         cos_q [3];

  assign angle = {angle_z_i, angle_y_i, angle_x_i};

  for (genvar g = 0; g < 3; g++) begin : g_axis
    logic [TBL_W-1:0]           qsin_tbl [TBL_DEPTH];
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ADDR_W-1:0]          addr_a;
    logic [ADDR_W-1:0]          addr_b;
    logic [TBL_W-1:0]           ta_q;
    logic [TBL_W-1:0]           tb_q;
    logic [1:0]                 quad_q;
    logic [TBL_W-1:0]           sin_mag;
    logic [TBL_W-1:0]           cos_mag;

    for (genvar j = 0; j < TBL_DEPTH; j++) begin : g_rom
      assign qsin_tbl[j] = quarter_sine_q15(15'(j << SHIFT));
    end

    // the two mirrored addresses inside the quarter wave feed sine and cosine
    assign idx    = angle[g][ANGLE_W-1:SHIFT];
    assign addr_a = ADDR_W'(idx[RIDX_W-1:0]);
    assign addr_b = ADDR_W'(QTR) - ADDR_W'(idx[RIDX_W-1:0]);

    always_ff @(posedge clk_i) begin
      if (rdy[1] && in_valid_i) begin
        ta_q   <= qsin_tbl[addr_a];
        tb_q   <= qsin_tbl[addr_b];
        quad_q <= idx[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
      end
    end

    assign sin_mag = quad_q[0] ? tb_q : ta_q;
    assign cos_mag = quad_q[0] ? ta_q : tb_q;

    // sine is negative in the lower half turn, cosine in quadrants one and two
    always_ff @(posedge clk_i) begin
      if (rdy[2]) begin
        sin_q[g] <= quad_q[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        cos_q[g] <= (quad_q[1] ^ quad_q[0]) ? -$signed({1'b0, cos_mag})
                                             : $signed({1'b0, cos_mag});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pair products, Q2.30
  // ---------------------------------------------------------------------------
  logic signed [P2_W-1:0]  cycz_q, cysz_q, sxcy_q, cxcy_q;
  logic signed [P2_W-1:0]  cxsz_q, sxcz_q, sxsz_q, cxcz_q;
  logic signed [Q15_W-1:0] sy3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      cycz_q <= cos_q[1] * cos_q[2];
      cysz_q <= cos_q[1] * sin_q[2];
      sxcy_q <= sin_q[0] * cos_q[1];
      cxcy_q <= cos_q[0] * cos_q[1];
      cxsz_q <= cos_q[0] * sin_q[2];
      sxcz_q <= sin_q[0] * cos_q[2];
      sxsz_q <= sin_q[0] * sin_q[2];
      cxcz_q <= cos_q[0] * cos_q[2];
      sy3_q  <= sin_q[1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: triple products with sin y, Q3.45; pass the pair products along
  // ---------------------------------------------------------------------------
  logic signed [P3_W-1:0]  sxczsy_q, cxczsy_q, sxszsy_q, cxszsy_q;
  logic signed [P2_W-1:0]  cycz4_q, cysz4_q, sxcy4_q, cxcy4_q;
  logic signed [P2_W-1:0]  cxsz4_q, sxcz4_q, sxsz4_q, cxcz4_q;
  logic signed [Q15_W-1:0] sy4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      sxczsy_q <= sxcz_q * sy3_q;
      cxczsy_q <= cxcz_q * sy3_q;
      sxszsy_q <= sxsz_q * sy3_q;
      cxszsy_q <= cxsz_q * sy3_q;
      cycz4_q  <= cycz_q;
      cysz4_q  <= cysz_q;
      sxcy4_q  <= sxcy_q;
      cxcy4_q  <= cxcy_q;
      cxsz4_q  <= cxsz_q;
      sxcz4_q  <= sxcz_q;
      sxsz4_q  <= sxsz_q;
      cxcz4_q  <= cxcz_q;
      sy4_q    <= sy3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: exact Q45 sums plus the half-LSB rounding offset
  // ---------------------------------------------------------------------------
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'sd1 <<< 29);

  logic signed [SUM_W-1:0] sum_d [9];
  logic signed [SUM_W-1:0] sum_q [9];

  always_comb begin
    sum_d[0] = (SUM_W'(cycz4_q) <<< 15) + RND_HALF;
    sum_d[1] = SUM_W'(sxczsy_q) - (SUM_W'(cxsz4_q) <<< 15) + RND_HALF;
    sum_d[2] = (SUM_W'(sxsz4_q) <<< 15) + SUM_W'(cxczsy_q) + RND_HALF;
    sum_d[3] = (SUM_W'(cysz4_q) <<< 15) + RND_HALF;
    sum_d[4] = (SUM_W'(cxcz4_q) <<< 15) + SUM_W'(sxszsy_q) + RND_HALF;
    sum_d[5] = SUM_W'(cxszsy_q) - (SUM_W'(sxcz4_q) <<< 15) + RND_HALF;
    sum_d[6] = RND_HALF - (SUM_W'(sy4_q) <<< 30);
    sum_d[7] = (SUM_W'(sxcy4_q) <<< 15) + RND_HALF;
    sum_d[8] = (SUM_W'(cxcy4_q) <<< 15) + RND_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int i = 0; i < 9; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: drop the low 30 bits (floor) and clamp to +-32767
  // ---------------------------------------------------------------------------
  logic signed [RND_W-1:0] rnd   [9];
  logic signed [Q15_W-1:0] res_d [9];
  logic signed [Q15_W-1:0] res_q [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rnd[i] = sum_q[i][SUM_W-1:30];
      if (rnd[i] > RND_W'(Q15_MAX)) begin
        res_d[i] = Q15_MAX;
      end else if (rnd[i] < -RND_W'(Q15_MAX)) begin
        res_d[i] = -Q15_MAX;
      end else begin
        res_d[i] = rnd[i][Q15_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      for (int i = 0; i < 9; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

  assign m00_o = res_q[0];
  assign m01_o = res_q[1];
  assign m02_o = res_q[2];
  assign m10_o = res_q[3];
  assign m11_o = res_q[4];
  assign m12_o = res_q[5];
  assign m20_o = res_q[6];
  assign m21_o = res_q[7];
  assign m22_o = res_q[8];

endmodule
